// ===== rtl/sphere_overlap_push_apart_top_assert.svh =====
// Assertion macros for the sphere overlap push-apart block.
// Depends on nothing; included by sop_queue, which checks itself.
`ifndef SPHERE_OVERLAP_PUSH_APART_TOP_ASSERT_SVH
`define SPHERE_OVERLAP_PUSH_APART_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SOP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define SOP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/sop_pkg.sv =====
// Package for the sphere overlap push-apart block: widths, types, helpers.
// Depends on nothing.
package sop_pkg;
    localparam int CoordW = 32;
    localparam int RadW   = 24;
    localparam int SumW   = RadW + 1;      // radius sum
    localparam int DiffW  = CoordW + 1;    // per-axis difference
    localparam int SqW    = 64;            // squared values
    localparam int RootW  = 32;            // floor(sqrt) of a 64-bit value
    localparam int QDepth = 2;             // front-to-back queue depth
    localparam int QAw    = 1;

    typedef struct packed {
        logic signed [CoordW-1:0] self_x;
        logic signed [CoordW-1:0] self_y;
        logic signed [CoordW-1:0] self_z;
        logic signed [CoordW-1:0] other_x;
        logic signed [CoordW-1:0] other_y;
        logic signed [CoordW-1:0] other_z;
        logic [RadW-1:0]          self_radius;
        logic [RadW-1:0]          other_radius;
    } sop_in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] new_self_x;
        logic signed [CoordW-1:0] new_self_y;
        logic signed [CoordW-1:0] new_self_z;
        logic signed [CoordW-1:0] new_other_x;
        logic signed [CoordW-1:0] new_other_y;
        logic signed [CoordW-1:0] new_other_z;
        logic                     overlapped;
    } sop_out_t;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic signed [CoordW-1:0] sx, sy, sz, ox, oy, oz;
        logic signed [DiffW-1:0]  dx, dy, dz;
        logic [SqW-1:0]           d2;
        logic [SumW-1:0]          rsum;
        logic                     hit;
    } sop_job_t;

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [DiffW+1:0] v);
        logic signed [DiffW+1:0] maxv;
        logic signed [DiffW+1:0] minv;
        maxv = (DiffW+2)'((longint'(1) <<< (CoordW-1)) - longint'(1));
        minv = -(DiffW+2)'(longint'(1) <<< (CoordW-1));
        if (v > maxv)
            return maxv[CoordW-1:0];
        else if (v < minv)
            return minv[CoordW-1:0];
        else
            return v[CoordW-1:0];
    endfunction
endpackage

// ===== rtl/sop_stream_if.sv =====
// Valid/ready stream interface carrying one packed payload.
// Depends on nothing; the payload type is given per instance.
interface sop_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sop_front.sv =====
// Front end: differences, squared distance, radius sum, overlap decision.
// Depends on sop_pkg. Two register stages with stall propagation.
module sop_front
    import sop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sop_in_t  in_data,
    output logic     job_valid,
    input  logic     job_ready,
    output sop_job_t job
);
    logic s1_v_reg, s2_v_reg;
    logic s1_en, s2_en;
    logic signed [CoordW-1:0] sx_reg, sy_reg, sz_reg, ox_reg, oy_reg, oz_reg;
    logic signed [DiffW-1:0] dx_reg, dy_reg, dz_reg;
    logic [SqW-1:0] qx_reg, qy_reg, qz_reg;
    logic [SumW-1:0] r_reg;
    logic [2*SumW-1:0] r2_reg;
    sop_job_t job_reg, job_next;
    logic signed [DiffW-1:0] dxn, dyn, dzn;
    logic [CoordW-1:0] ax, ay, az;
    logic [SqW-1:0] qxn, qyn, qzn;
    logic [SumW-1:0] rn;
    logic [2*SumW-1:0] r2n;
    logic [SqW:0] sum1;
    logic [SqW+1:0] sum2;

    assign s2_en    = !s2_v_reg || job_ready;
    assign s1_en    = !s1_v_reg || s2_en;
    assign in_ready = s1_en;

    assign dxn = DiffW'(in_data.other_x) - DiffW'(in_data.self_x);
    assign dyn = DiffW'(in_data.other_y) - DiffW'(in_data.self_y);
    assign dzn = DiffW'(in_data.other_z) - DiffW'(in_data.self_z);
    assign ax = dxn[DiffW-1] ? CoordW'(-dxn) : dxn[CoordW-1:0];
    assign ay = dyn[DiffW-1] ? CoordW'(-dyn) : dyn[CoordW-1:0];
    assign az = dzn[DiffW-1] ? CoordW'(-dzn) : dzn[CoordW-1:0];

    // Square each axis and the radius sum; one multiplier per value.
    assign qxn = ax * ax;
    assign qyn = ay * ay;
    assign qzn = az * az;
    assign rn  = SumW'(in_data.self_radius) + SumW'(in_data.other_radius);
    assign r2n = rn * rn;

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            sx_reg <= in_data.self_x;
            sy_reg <= in_data.self_y;
            sz_reg <= in_data.self_z;
            ox_reg <= in_data.other_x;
            oy_reg <= in_data.other_y;
            oz_reg <= in_data.other_z;
            dx_reg <= dxn;
            dy_reg <= dyn;
            dz_reg <= dzn;
            qx_reg <= qxn;
            qy_reg <= qyn;
            qz_reg <= qzn;
            r_reg  <= rn;
            r2_reg <= r2n;
        end
    end

    // |d| < 2^32 so each square fits 64 bits; the exact 66-bit sum then saturates.
    always_comb
    begin
        sum1 = (SqW+1)'(qx_reg) + (SqW+1)'(qy_reg);
        sum2 = (SqW+2)'(sum1) + (SqW+2)'(qz_reg);
        job_next.sx   = sx_reg;
        job_next.sy   = sy_reg;
        job_next.sz   = sz_reg;
        job_next.ox   = ox_reg;
        job_next.oy   = oy_reg;
        job_next.oz   = oz_reg;
        job_next.dx   = dx_reg;
        job_next.dy   = dy_reg;
        job_next.dz   = dz_reg;
        job_next.d2   = (sum2[SqW+1:SqW] != 2'b00) ? '1 : sum2[SqW-1:0];
        job_next.rsum = r_reg;
        job_next.hit  = job_next.d2 < SqW'(r2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_v_reg)
            job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_v_reg <= in_valid;
            if (s2_en)
                s2_v_reg <= s1_v_reg;
        end
    end

    assign job_valid = s2_v_reg;
    assign job       = job_reg;
endmodule

// ===== rtl/sop_queue.sv =====
// Two-entry queue between the front and back ends.
// Depends on sop_pkg and sphere_overlap_push_apart_top_assert.svh.
module sop_queue
    import sop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  sop_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output sop_job_t rd_data
);
    `include "sphere_overlap_push_apart_top_assert.svh"

    sop_job_t mem_reg [QDepth];
    logic [QAw-1:0] wp_reg, rp_reg;
    logic [QAw:0] cnt_reg;
    logic wr_en, rd_en;

    assign wr_ready = cnt_reg != (QAw+1)'(QDepth);
    assign rd_valid = cnt_reg != '0;
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAw+1)'(wr_en) - (QAw+1)'(rd_en);
        end
    end

    `SOP_ASSERT_IMP(a_q_bound, 1'b1, cnt_reg <= (QAw+1)'(QDepth))
    `SOP_ASSERT_NXT(a_q_hold, rd_valid && !rd_ready, rd_valid && $stable(rp_reg))
    `SOP_ASSERT_IMP(a_q_ptr, cnt_reg == '0 || cnt_reg == (QAw+1)'(QDepth), wp_reg == rp_reg)
endmodule

// ===== rtl/sop_back.sv =====
// Back end: integer square root, overlap, per-axis push by division, saturation.
// Depends on sop_pkg. Fully pipelined: root and dividers one bit per stage.
module sop_back
    import sop_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_ready,
    input  sop_job_t job,
    output logic     out_valid,
    input  logic     out_ready,
    output sop_out_t out_data
);
    // Only hits reach the root and division, so dist < 2^25 and |d| <= dist.
    localparam int RtSt  = 25;            // root stages, one result bit each
    localparam int DvW   = 26;            // divisor / |d| width
    localparam int NumW  = 2*DvW;         // |d| * overlap
    localparam int DvSt  = 50;            // quotient bits (q <= overlap < 2^25 ... safe)
    localparam int Lat   = 2 + RtSt + 2 + DvSt + 1;

    logic adv;
    logic v_reg [Lat];

    // Stage registers: job carried alongside.
    sop_job_t jr_reg [Lat];

    // Root pipeline: remainder and partial root.
    logic [SqW-1:0] rn_reg [RtSt+1];
    logic [RootW-1:0] rr_reg [RtSt+1];

    // Division pipeline: three lanes.
    logic [DvW-1:0] dist_reg, ov_reg;
    logic [NumW-1:0] num_reg [3][DvSt+1];
    logic [NumW-1:0] rem_reg [3][DvSt+1];
    logic [NumW-1:0] quo_reg [3][DvSt+1];
    logic [DvW-1:0]  dv_reg [DvSt+1];
    logic [DvW-1:0]  ovp_reg [DvSt+1];
    logic [DvW-1:0]  ab_reg [3];
    sop_out_t res_reg;

    assign adv       = !v_reg[Lat-1] || out_ready;
    assign job_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < Lat; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= job_valid;
            for (int i = 1; i < Lat; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            jr_reg[0] <= job;
            for (int i = 1; i < Lat; i++)
                jr_reg[i] <= jr_reg[i-1];
        end
    end

    // Root: bit-by-bit restoring, one result bit per stage (value < 2^50 on hits).
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rn_reg[0] <= jr_reg[0].hit ? jr_reg[0].d2 : '0;
            rr_reg[0] <= '0;
            for (int k = 0; k < RtSt; k++)
            begin
                logic [SqW-1:0] trial;
                trial = ({32'd0, rr_reg[k]} << (RtSt - k)) + (SqW'(1) << (2*(RtSt-1-k)));
                if (rn_reg[k] >= trial)
                begin
                    rn_reg[k+1] <= rn_reg[k] - trial;
                    rr_reg[k+1] <= rr_reg[k] | (RootW'(1) << (RtSt-1-k));
                end
                else
                begin
                    rn_reg[k+1] <= rn_reg[k];
                    rr_reg[k+1] <= rr_reg[k];
                end
            end
        end
    end

    // Overlap and numerators: stage index RtSt+1 holds job matching rr_reg[RtSt].
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= DvW'(rr_reg[RtSt]);
            ov_reg   <= DvW'((DvW'(jr_reg[RtSt+1].rsum) - DvW'(rr_reg[RtSt])) >> 1);
            ab_reg[0] <= jr_reg[RtSt+1].dx[DiffW-1] ? DvW'(-jr_reg[RtSt+1].dx)
                                                    : DvW'(jr_reg[RtSt+1].dx);
            ab_reg[1] <= jr_reg[RtSt+1].dy[DiffW-1] ? DvW'(-jr_reg[RtSt+1].dy)
                                                    : DvW'(jr_reg[RtSt+1].dy);
            ab_reg[2] <= jr_reg[RtSt+1].dz[DiffW-1] ? DvW'(-jr_reg[RtSt+1].dz)
                                                    : DvW'(jr_reg[RtSt+1].dz);
            // one 26x26 multiply per lane, registered before the divider
            for (int l = 0; l < 3; l++)
            begin
                num_reg[l][0] <= ab_reg[l] * ov_reg;
                rem_reg[l][0] <= '0;
                quo_reg[l][0] <= '0;
            end
            dv_reg[0]  <= dist_reg;
            ovp_reg[0] <= ov_reg;
            for (int k = 0; k < DvSt; k++)
            begin
                dv_reg[k+1]  <= dv_reg[k];
                ovp_reg[k+1] <= ovp_reg[k];
                for (int l = 0; l < 3; l++)
                begin
                    logic [NumW:0] r2;
                    r2 = {rem_reg[l][k], num_reg[l][k][NumW-1-k]};
                    num_reg[l][k+1] <= num_reg[l][k];
                    if (r2 >= (NumW+1)'(dv_reg[k]) && dv_reg[k] != '0)
                    begin
                        rem_reg[l][k+1] <= NumW'(r2 - (NumW+1)'(dv_reg[k]));
                        quo_reg[l][k+1] <= quo_reg[l][k] | (NumW'(1) << (NumW-1-k));
                    end
                    else
                    begin
                        rem_reg[l][k+1] <= NumW'(r2);
                        quo_reg[l][k+1] <= quo_reg[l][k];
                    end
                end
            end
        end
    end

    // Final: only the low DvW quotient bits are kept; quotient < 2^25 so the low NumW-DvSt bits
    // are handled by noting num < 2^52 and DvSt covers bits 51..2; finish the rest here.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sop_job_t j;
            logic signed [DiffW+1:0] p [3];
            logic [NumW:0] r2a, r2b;
            logic [NumW-1:0] q, ra;
            j = jr_reg[Lat-2];
            for (int l = 0; l < 3; l++)
            begin
                ra = rem_reg[l][DvSt];
                q  = quo_reg[l][DvSt];
                r2a = {ra, num_reg[l][DvSt][1]};
                if (r2a >= (NumW+1)'(dv_reg[DvSt]))
                begin
                    ra = NumW'(r2a - (NumW+1)'(dv_reg[DvSt]));
                    q  = q | NumW'(2);
                end
                else
                    ra = NumW'(r2a);
                r2b = {ra, num_reg[l][DvSt][0]};
                if (r2b >= (NumW+1)'(dv_reg[DvSt]))
                    q = q | NumW'(1);
                p[l] = (DiffW+2)'(q[DvW-1:0]);
            end
            if (dv_reg[DvSt] == '0)
            begin
                p[0] = (DiffW+2)'(ovp_reg[DvSt]);
                p[1] = '0;
                p[2] = '0;
            end
            else
            begin
                if (j.dx[DiffW-1]) p[0] = -p[0];
                if (j.dy[DiffW-1]) p[1] = -p[1];
                if (j.dz[DiffW-1]) p[2] = -p[2];
            end
            if (!j.hit)
            begin
                p[0] = '0;
                p[1] = '0;
                p[2] = '0;
            end
            res_reg.new_self_x  <= sat32((DiffW+2)'(j.sx) - p[0]);
            res_reg.new_self_y  <= sat32((DiffW+2)'(j.sy) - p[1]);
            res_reg.new_self_z  <= sat32((DiffW+2)'(j.sz) - p[2]);
            res_reg.new_other_x <= sat32((DiffW+2)'(j.ox) + p[0]);
            res_reg.new_other_y <= sat32((DiffW+2)'(j.oy) + p[1]);
            res_reg.new_other_z <= sat32((DiffW+2)'(j.oz) + p[2]);
            res_reg.overlapped  <= j.hit;
        end
    end

    assign out_valid = v_reg[Lat-1];
    assign out_data  = res_reg;
endmodule

// ===== rtl/sphere_overlap_push_apart_top.sv =====
// Sphere overlap push-apart: one pair per cycle while the result side takes results.
// Pipeline: 2 front stages, a two-entry queue, then 80 back stages (25-stage root, 50-stage divide).
// Throughput: one transfer per cycle in and out while the result side takes results.
// Reset: rst_n asynchronous, active low; clears all valid flags and queue pointers.
// Depends on sop_pkg, sop_stream_if, sop_front, sop_queue, sop_back.
module sphere_overlap_push_apart_top
    import sop_pkg::*;
(
    input logic clk,
    input logic rst_n,
    sop_stream_if.sink   in_ch,
    sop_stream_if.source out_ch
);
    logic     f_valid, f_ready, b_valid, b_ready;
    sop_job_t f_job, b_job;

    // Front: classify the pair as overlapping or not.
    sop_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    // Queue: decouple front stalls from back stalls.
    sop_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_job)
    );

    // Back: root, divide, apply push, saturate.
    sop_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data)
    );
endmodule

// ===== bench/sphere_overlap_push_apart_top_test.sv =====
// Testbench for the sphere overlap push-apart block: directed and random pairs,
// checked against an in-bench collision predictor through a small scoreboard class.
// Depends on sop_pkg, sop_stream_if and sphere_overlap_push_apart_top.
`timescale 1ns / 100ps

module sphere_overlap_push_apart_top_test
    import sop_pkg::*;
();

    localparam int LatencyCycles = 100;
    localparam longint CycleLimit = 2000000;

    // Predict one push-apart result from a pair of spheres.
    function automatic sop_out_t predict_push(input sop_in_t p);
        logic signed [63:0] s [3];
        logic signed [63:0] o [3];
        logic signed [63:0] d [3];
        logic signed [63:0] push [3];
        logic [63:0] mag, sq, d2, rad, rad2, rem, root, bitv, ov, q;
        logic [64:0] acc;
        sop_out_t r;
        logic signed [63:0] v;
        s[0] = p.self_x;  s[1] = p.self_y;  s[2] = p.self_z;
        o[0] = p.other_x; o[1] = p.other_y; o[2] = p.other_z;
        d2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = o[i] - s[i];
            push[i] = 0;
            mag = (d[i] < 0) ? -d[i] : d[i];
            sq = mag * mag;
            acc = {1'b0, d2} + {1'b0, sq};
            d2 = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
        end
        rad = 64'(p.self_radius) + 64'(p.other_radius);
        rad2 = rad * rad;
        r.overlapped = (d2 < rad2);
        if (r.overlapped)
        begin
            // Bitwise integer square root.
            rem = d2;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (rem >= root + bitv)
                begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv = bitv >> 2;
            end
            ov = (rad - root) >> 1;
            if (root != 0)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag = (d[i] < 0) ? -d[i] : d[i];
                    q = (mag * ov) / root;
                    push[i] = (d[i] < 0) ? -$signed(q) : $signed(q);
                end
            end
            else
                push[0] = $signed(ov);
        end
        for (int i = 0; i < 3; i++)
        begin
            v = s[i] - push[i];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            case (i)
                0: r.new_self_x = v[31:0];
                1: r.new_self_y = v[31:0];
                default: r.new_self_z = v[31:0];
            endcase
            v = o[i] + push[i];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            case (i)
                0: r.new_other_x = v[31:0];
                1: r.new_other_y = v[31:0];
                default: r.new_other_z = v[31:0];
            endcase
        end
        return r;
    endfunction

    class push_scoreboard;
        sop_out_t pending[$];
        int errors = 0;

        function void note_pair(sop_in_t p);
            pending.push_back(predict_push(p));
        endfunction

        function void check_result(sop_out_t got);
            sop_out_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.new_self_x !== want.new_self_x)
                $display("%0t: new_self_x expected %h got %h", $time,
                         want.new_self_x, got.new_self_x);
            if (got.new_self_y !== want.new_self_y)
                $display("%0t: new_self_y expected %h got %h", $time,
                         want.new_self_y, got.new_self_y);
            if (got.new_self_z !== want.new_self_z)
                $display("%0t: new_self_z expected %h got %h", $time,
                         want.new_self_z, got.new_self_z);
            if (got.new_other_x !== want.new_other_x)
                $display("%0t: new_other_x expected %h got %h", $time,
                         want.new_other_x, got.new_other_x);
            if (got.new_other_y !== want.new_other_y)
                $display("%0t: new_other_y expected %h got %h", $time,
                         want.new_other_y, got.new_other_y);
            if (got.new_other_z !== want.new_other_z)
                $display("%0t: new_other_z expected %h got %h", $time,
                         want.new_other_z, got.new_other_z);
            if (got.overlapped !== want.overlapped)
                $display("%0t: overlapped expected %b got %b", $time,
                         want.overlapped, got.overlapped);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    sop_stream_if #(.payload_t(sop_in_t))  in_ch ();
    sop_stream_if #(.payload_t(sop_out_t)) out_ch ();

    sphere_overlap_push_apart_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    push_scoreboard board;
    int send_idle_pct;      // chance per cycle that the sender holds off
    int recv_stall_pct;     // chance per cycle that the receiver stalls
    bit hold_off_req;       // ask the receiver for one long stall
    bit hold_off_busy;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles and end the run on a timeout.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CycleLimit)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Receiver: drive ready, take transfers and check them.
    initial
    begin
        out_ch.ready = 1'b0;
        hold_off_busy = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.data);
            if (hold_off_req && !hold_off_busy)
            begin
                // Long stall so the block fills and backs up its input.
                hold_off_busy = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off_req = 1'b0;
                hold_off_busy = 1'b0;
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(65535 * 4)) - 32'sd131072;
            default: return $signed($urandom_range(2000000)) - 32'sd1000000;
        endcase
    endfunction

    // Pair near the first centre in most draws so that overlap is likely.
    function automatic sop_in_t rand_pair();
        sop_in_t p;
        p.self_x = rand_coord();
        p.self_y = rand_coord();
        p.self_z = rand_coord();
        if ($urandom_range(9) < 7)
        begin
            p.other_x = p.self_x + ($signed($urandom_range(400000)) - 200000);
            p.other_y = p.self_y + ($signed($urandom_range(400000)) - 200000);
            p.other_z = p.self_z + ($signed($urandom_range(400000)) - 200000);
        end
        else
        begin
            p.other_x = rand_coord();
            p.other_y = rand_coord();
            p.other_z = rand_coord();
        end
        p.self_radius  = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(300000));
        p.other_radius = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(300000));
        return p;
    endfunction

    // Offer one pair and hold it until the block takes it.
    task automatic send_pair(input sop_in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= p;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_pair(p);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (count)
            send_pair(rand_pair());
    endtask

    function automatic sop_in_t make_pair(input logic signed [31:0] sx, sy, sz, ox, oy, oz,
                                          input logic [23:0] sr, orad);
        sop_in_t p;
        p.self_x = sx; p.self_y = sy; p.self_z = sz;
        p.other_x = ox; p.other_y = oy; p.other_z = oz;
        p.self_radius = sr; p.other_radius = orad;
        return p;
    endfunction

    initial
    begin
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coincident centres push along x.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 24'h010000, 24'h010000));
        send_pair(make_pair(32'sh7FFF_FFFF, 5, -5, 32'sh7FFF_FFFF, 5, -5,
                            24'hFFFFFF, 24'hFFFFFF));
        // Touching spheres: no overlap.
        send_pair(make_pair(0, 0, 0, 32'sh0002_0000, 0, 0, 24'h010000, 24'h010000));
        // Zero radii.
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(10, 20, 30, 11, 20, 30, 0, 0));
        // Huge separation saturates the squared distance.
        send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            24'hFFFFFF, 24'hFFFFFF));
        // Pushes that saturate at the coordinate range; then huge separation with zero radii.
        send_pair(make_pair(32'sh8000_0000, 0, 0, 32'sh8000_1000, 0, 0,
                            24'hFFFFFF, 24'hFFFFFF));
        send_pair(make_pair(32'sh7FFF_F000, 0, 0, 32'sh7FFF_FFFF, 0, 0,
                            24'hFFFFFF, 24'hFFFFFF));
        send_pair(make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0));
        // Overlap on every axis, both signs.
        send_pair(make_pair(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000,
                            -32'sh0000_8000, 32'sh0000_8000, -32'sh0001_0000,
                            24'h030000, 24'h028000));
        send_pair(make_pair(-1, -1, -1, 1, 1, 1, 24'h000010, 24'h000001));
        // Every bit of both radii high, and every coordinate bit high but bit 0 of other_z.
        send_pair(make_pair(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF,
                            32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFE,
                            24'hFFFFFF, 24'hFFFFFF));
        drain();

        // Phase: no idling.
        run_random(200, 0, 0);
        // Long receiver hold-off while the sender keeps offering.
        hold_off_req = 1'b1;
        run_random(150, 0, 0);
        // Sender pauses until everything has come back.
        drain();
        run_random(150, 65, 0);
        run_random(150, 0, 65);
        run_random(150, 30, 30);
        drain();
        repeat (LatencyCycles) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
